// ----- sv/isdb_pkg.sv -----
`default_nettype none
package isdb_pkg;
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_DEL   = 2'd2,
      CMD_BUILD = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_FREE  = 2'd3
   } status_type;

   localparam int TypeCountBits = 5;
   localparam int ResultLimit   = 16;
   localparam int TypeIdBits    = 4;
   localparam int SlotBits      = 8;
   localparam int CountBits     = 24;
   localparam int GenOutBits    = 16;
   localparam int InstBits      = 9;
   localparam int SumBits       = 28;
endpackage
`default_nettype wire

// ----- sv/instance_slot_map_draw_builder.sv -----
// Every command is accepted into S_RD; load_type answers from there, delete passes through
// S_DEL, add through S_ADD (and S_EMIT when it reuses a freed slot), build through S_CLR
// and S_WALK. Throughput: one command at a time; build then gives one word per type per
// cycle while rsp_stall is low. Reset (synchronous, active high) clears control state,
// live marks, counters and per-type tables; slot type, generation and stack memories do not.
`default_nettype none
module instance_slot_map_draw_builder #(
   parameter int MAX_SLOTS = 256,
   parameter int MAX_TYPES = 16,
   parameter int GEN_BITS  = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [isdb_pkg::TypeCountBits-1:0]       csr_type_count,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  [1:0]                               req_cmd,
   input  wire  [isdb_pkg::TypeIdBits-1:0]          req_type_id,
   input  wire  [isdb_pkg::SlotBits-1:0]            req_slot_index,
   input  wire  [isdb_pkg::CountBits-1:0]           req_mesh_index_count,
   input  wire  [isdb_pkg::CountBits-1:0]           req_mesh_vertex_count,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [isdb_pkg::SlotBits-1:0]            rsp_handle_slot,
   output logic [isdb_pkg::GenOutBits-1:0]          rsp_handle_generation,
   output logic [isdb_pkg::CountBits-1:0]           rsp_draw_index_count,
   output logic [isdb_pkg::InstBits-1:0]            rsp_draw_instance_count,
   output logic [isdb_pkg::SumBits-1:0]             rsp_draw_first_index,
   output logic [isdb_pkg::SumBits-1:0]             rsp_draw_vertex_offset,
   output logic [isdb_pkg::InstBits-1:0]            rsp_draw_first_instance,
   output logic                                     rsp_last
);
   import isdb_pkg::*;

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int TW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int NW = $clog2(MAX_TYPES + 1);
   localparam int LIM = (MAX_TYPES < ResultLimit) ? MAX_TYPES : ResultLimit;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_ADD, S_DEL, S_CLR, S_WALK, S_EMIT, S_OUT
   } state_type;

   // slot memories: type and generation, free stack
   logic [TypeIdBits-1:0] type_mem [MAX_SLOTS];
   logic [GEN_BITS-1:0]   gen_mem [MAX_SLOTS];
   logic [SW-1:0]         stack_mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]  live_ff;

   logic [CountBits-1:0]  tidx_ff [MAX_TYPES];
   logic [CountBits-1:0]  tvtx_ff [MAX_TYPES];
   logic [InstBits-1:0]   tally_ff [MAX_TYPES];

   state_type             state_ff;
   logic [TypeCountBits-1:0] tcount_ff;
   logic [CW-1:0]         free_top_ff, used_ff;
   logic [1:0]            cmd_ff;
   logic [TypeIdBits-1:0] tid_ff;
   logic [SlotBits-1:0]   slot_ff;
   logic [CountBits-1:0]  icnt_ff, vcnt_ff;
   logic [SW-1:0]         sel_ff;
   logic [CW-1:0]         walk_ff;
   logic                  rd_vld_ff;
   logic [SW-1:0]         rd_slot_ff;
   logic [TypeIdBits-1:0] rd_type_ff;
   logic [GEN_BITS-1:0]   rd_gen_ff;
   logic [SW-1:0]         rd_stack_ff;
   logic [NW-1:0]         n_ff;
   logic [NW-1:0]         t_ff;
   logic [SumBits-1:0]    fi_ff, vo_ff;
   logic [InstBits-1:0]   finst_ff;

   // memory read address
   logic [SW-1:0] raddr;
   logic [SW-1:0] saddr;
   always_comb begin
      raddr = walk_ff[SW-1:0];
      if (state_ff == S_RD) begin
         raddr = SW'(slot_ff);
      end else if (state_ff == S_ADD) begin
         raddr = rd_stack_ff;
      end
      saddr = SW'(free_top_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      rd_type_ff  <= type_mem[raddr];
      rd_gen_ff   <= gen_mem[raddr];
      rd_stack_ff <= stack_mem[saddr];
   end

   logic [TypeCountBits-1:0] n_eff;
   always_comb begin
      n_eff = tcount_ff;
      if (32'(tcount_ff) > LIM) begin
         n_eff = TypeCountBits'(LIM);
      end
   end

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   logic [TypeIdBits-1:0] wt;
   assign wt = rd_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tcount_ff   <= TypeCountBits'(1);
         free_top_ff <= '0;
         used_ff     <= '0;
         live_ff     <= '0;
         rsp_valid   <= 1'b0;
         rd_vld_ff   <= 1'b0;
         for (int i = 0; i < MAX_TYPES; i++) begin
            tidx_ff[i]  <= '0;
            tvtx_ff[i]  <= '0;
            tally_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  tcount_ff <= csr_type_count;
               end
               if (req_valid) begin
                  cmd_ff  <= req_cmd;
                  tid_ff  <= req_type_id;
                  slot_ff <= req_slot_index;
                  icnt_ff <= req_mesh_index_count;
                  vcnt_ff <= req_mesh_vertex_count;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               rsp_status <= ST_OK;
               rsp_handle_slot <= '0;
               rsp_handle_generation <= '0;
               rsp_draw_index_count <= '0;
               rsp_draw_instance_count <= '0;
               rsp_draw_first_index <= '0;
               rsp_draw_vertex_offset <= '0;
               rsp_draw_first_instance <= '0;
               rsp_last <= 1'b1;
               case (cmd_ff)
                  CMD_LOAD: begin
                     if (32'(tid_ff) < MAX_TYPES) begin
                        tidx_ff[TW'(tid_ff)] <= icnt_ff;
                        tvtx_ff[TW'(tid_ff)] <= vcnt_ff;
                     end
                     rsp_valid <= 1'b1;
                     state_ff <= S_OUT;
                  end
                  CMD_ADD: state_ff <= S_ADD;
                  CMD_DEL: state_ff <= S_DEL;
                  default: begin
                     n_ff <= NW'(n_eff);
                     state_ff <= S_CLR;
                  end
               endcase
            end
            S_ADD: begin
               if (free_top_ff != '0) begin
                  live_ff[rd_stack_ff] <= 1'b1;
                  type_mem[rd_stack_ff] <= tid_ff;
                  free_top_ff <= free_top_ff - CW'(1);
                  sel_ff <= rd_stack_ff;
                  state_ff <= S_EMIT;
               end else if (32'(used_ff) < MAX_SLOTS) begin
                  live_ff[used_ff[SW-1:0]] <= 1'b1;
                  type_mem[used_ff[SW-1:0]] <= tid_ff;
                  gen_mem[used_ff[SW-1:0]] <= '0;
                  used_ff <= used_ff + CW'(1);
                  rsp_handle_slot <= SlotBits'(used_ff);
                  rsp_valid <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  rsp_status <= ST_FULL;
                  rsp_valid <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_EMIT: begin
               // generation read of reused slot
               rsp_handle_slot <= SlotBits'(sel_ff);
               rsp_handle_generation <= GenOutBits'(rd_gen_ff);
               rsp_valid <= 1'b1;
               state_ff <= S_OUT;
            end
            S_DEL: begin
               rsp_handle_slot <= slot_ff;
               if (32'(slot_ff) >= 32'(used_ff) || 32'(slot_ff) >= MAX_SLOTS) begin
                  rsp_status <= ST_RANGE;
               end else if (!live_ff[SW'(slot_ff)]) begin
                  rsp_status <= ST_FREE;
               end else begin
                  live_ff[SW'(slot_ff)] <= 1'b0;
                  gen_mem[SW'(slot_ff)] <= rd_gen_ff + GEN_BITS'(1);
                  if (32'(free_top_ff) < MAX_SLOTS) begin
                     stack_mem[free_top_ff[SW-1:0]] <= SW'(slot_ff);
                     free_top_ff <= free_top_ff + CW'(1);
                  end
               end
               rsp_valid <= 1'b1;
               state_ff <= S_OUT;
            end
            S_CLR: begin
               for (int i = 0; i < MAX_TYPES; i++) begin
                  tally_ff[i] <= '0;
               end
               walk_ff <= '0;
               rd_vld_ff <= 1'b0;
               fi_ff <= '0;
               vo_ff <= '0;
               finst_ff <= '0;
               t_ff <= '0;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (rd_vld_ff && live_ff[rd_slot_ff] && 32'(wt) < 32'(n_ff)) begin
                  tally_ff[TW'(wt)] <= tally_ff[TW'(wt)] + InstBits'(1);
               end
               rd_slot_ff <= walk_ff[SW-1:0];
               if (walk_ff < used_ff) begin
                  rd_vld_ff <= 1'b1;
                  walk_ff <= walk_ff + CW'(1);
               end else begin
                  rd_vld_ff <= 1'b0;
                  if (!rd_vld_ff) begin
                     if (n_ff == '0) begin
                        state_ff <= S_IDLE;
                     end else begin
                        state_ff <= S_OUT;
                        rsp_valid <= 1'b1;
                        rsp_draw_index_count <= tidx_ff[0];
                        rsp_draw_instance_count <= tally_ff[0];
                        rsp_last <= (n_ff == NW'(1));
                        t_ff <= NW'(1);
                        fi_ff <= SumBits'(tidx_ff[0]);
                        vo_ff <= SumBits'(tvtx_ff[0]);
                        finst_ff <= tally_ff[0];
                     end
                  end
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (cmd_ff == CMD_BUILD && t_ff < n_ff) begin
                     rsp_draw_index_count <= tidx_ff[TW'(t_ff)];
                     rsp_draw_instance_count <= tally_ff[TW'(t_ff)];
                     rsp_draw_first_index <= fi_ff;
                     rsp_draw_vertex_offset <= vo_ff;
                     rsp_draw_first_instance <= finst_ff;
                     rsp_last <= (t_ff + NW'(1) == n_ff);
                     fi_ff <= fi_ff + SumBits'(tidx_ff[TW'(t_ff)]);
                     vo_ff <= vo_ff + SumBits'(tvtx_ff[TW'(t_ff)]);
                     finst_ff <= finst_ff + tally_ff[TW'(t_ff)];
                     t_ff <= t_ff + NW'(1);
                  end else begin
                     rsp_valid <= 1'b0;
                     t_ff <= '0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid)
      else $error("word after last");
   assert property (@(posedge clock) disable iff (reset)
      free_top_ff <= used_ff)
      else $error("free stack deeper than used slots");
   assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= MAX_SLOTS)
      else $error("used count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
endmodule
`default_nettype wire

// ----- dv/draw_builder_checker.sv -----
`timescale 1ns / 1ps
module draw_builder_checker
   import isdb_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_valid,
   input  wire                  csr_ready,
   input  wire [TypeCountBits-1:0] csr_type_count,
   input  wire                  req_valid,
   input  wire                  req_stall,
   input  wire [1:0]            req_cmd,
   input  wire [TypeIdBits-1:0] req_type_id,
   input  wire [SlotBits-1:0]   req_slot_index,
   input  wire [CountBits-1:0]  req_mesh_index_count,
   input  wire [CountBits-1:0]  req_mesh_vertex_count,
   input  wire                  rsp_valid,
   input  wire                  rsp_stall,
   input  wire [1:0]            rsp_status,
   input  wire [SlotBits-1:0]   rsp_handle_slot,
   input  wire [GenOutBits-1:0] rsp_handle_generation,
   input  wire [CountBits-1:0]  rsp_draw_index_count,
   input  wire [InstBits-1:0]   rsp_draw_instance_count,
   input  wire [SumBits-1:0]    rsp_draw_first_index,
   input  wire [SumBits-1:0]    rsp_draw_vertex_offset,
   input  wire [InstBits-1:0]   rsp_draw_first_instance,
   input  wire                  rsp_last,
   output int                   fail_count,
   output int                   pending
);
   typedef struct packed {
      logic [1:0]            status;
      logic [SlotBits-1:0]   slot;
      logic [GenOutBits-1:0] generation;
      logic [CountBits-1:0]  index_count;
      logic [InstBits-1:0]   instances;
      logic [SumBits-1:0]    first_index;
      logic [SumBits-1:0]    vertex_offset;
      logic [InstBits-1:0]   first_instance;
      logic                  last;
   } draw_word_type;

   localparam int NumSlots = 256;
   localparam int NumTypes = 16;

   draw_word_type        expected_words[$];
   logic                 live[NumSlots];
   logic [TypeIdBits-1:0] slot_kind[NumSlots];
   logic [GenOutBits-1:0] slot_gen[NumSlots];
   logic [SlotBits-1:0]  free_slots[NumSlots];
   int                   free_depth;
   int                   fresh_next;
   logic [CountBits-1:0] mesh_indices[NumTypes];
   logic [CountBits-1:0] mesh_vertices[NumTypes];
   logic [TypeCountBits-1:0] type_count;

   assign pending = expected_words.size();

   function automatic draw_word_type status_word(status_type st, logic [SlotBits-1:0] s,
                                                 logic [GenOutBits-1:0] g);
      draw_word_type w;
      w = '0;
      w.status = st;
      w.slot = s;
      w.generation = g;
      w.last = 1'b1;
      return w;
   endfunction

   task automatic queue_word(draw_word_type w);
      expected_words = {expected_words, w};
   endtask

   task automatic predict_command();
      int s;
      int n;
      logic [InstBits-1:0] tally[NumTypes];
      logic [SumBits-1:0]  idx_sum;
      logic [SumBits-1:0]  vtx_sum;
      logic [InstBits-1:0] inst_sum;
      draw_word_type w;
      case (cmd_type'(req_cmd))
         CMD_LOAD: begin
            mesh_indices[req_type_id] = req_mesh_index_count;
            mesh_vertices[req_type_id] = req_mesh_vertex_count;
            queue_word(status_word(ST_OK, '0, '0));
         end
         CMD_ADD: begin
            s = -1;
            if (free_depth > 0) begin
               free_depth--;
               s = free_slots[free_depth];
            end else if (fresh_next < NumSlots) begin
               s = fresh_next;
               fresh_next++;
               slot_gen[s] = '0;
            end
            if (s < 0) begin
               queue_word(status_word(ST_FULL, '0, '0));
            end else begin
               live[s] = 1'b1;
               slot_kind[s] = req_type_id;
               queue_word(status_word(ST_OK, s[SlotBits-1:0], slot_gen[s]));
            end
         end
         CMD_DEL: begin
            s = req_slot_index;
            if (s >= fresh_next) begin
               queue_word(status_word(ST_RANGE, req_slot_index, '0));
            end else if (!live[s]) begin
               queue_word(status_word(ST_FREE, req_slot_index, '0));
            end else begin
               live[s] = 1'b0;
               slot_gen[s] = slot_gen[s] + 1'b1;
               free_slots[free_depth] = req_slot_index;
               free_depth++;
               queue_word(status_word(ST_OK, req_slot_index, '0));
            end
         end
         default: begin
            n = (type_count > NumTypes) ? NumTypes : type_count;
            for (int t = 0; t < NumTypes; t++) tally[t] = '0;
            for (int k = 0; k < fresh_next; k++)
               if (live[k] && slot_kind[k] < n) tally[slot_kind[k]]++;
            idx_sum = '0;
            vtx_sum = '0;
            inst_sum = '0;
            for (int t = 0; t < n; t++) begin
               w = '0;
               w.status = ST_OK;
               w.index_count = mesh_indices[t];
               w.instances = tally[t];
               w.first_index = idx_sum;
               w.vertex_offset = vtx_sum;
               w.first_instance = inst_sum;
               w.last = (t == n - 1);
               queue_word(w);
               idx_sum = idx_sum + mesh_indices[t];
               vtx_sum = vtx_sum + mesh_vertices[t];
               inst_sum = inst_sum + tally[t];
            end
         end
      endcase
   endtask

   draw_word_type seen;
   draw_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         for (int k = 0; k < NumSlots; k++) live[k] = 1'b0;
         for (int t = 0; t < NumTypes; t++) begin
            mesh_indices[t] = '0;
            mesh_vertices[t] = '0;
         end
         free_depth = 0;
         fresh_next = 0;
         type_count = 1;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) type_count = csr_type_count;
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_handle_slot, rsp_handle_generation, rsp_draw_index_count,
                    rsp_draw_instance_count, rsp_draw_first_index, rsp_draw_vertex_offset,
                    rsp_draw_first_instance, rsp_last};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected word: %p", seen);
            end else begin
               want = expected_words.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, seen);
               end
            end
         end
         if (req_valid && !req_stall) predict_command();
      end
   end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import isdb_pkg::*;

   localparam int CycleLimit = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TypeCountBits-1:0] csr_type_count = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [TypeIdBits-1:0] req_type_id = '0;
   logic [SlotBits-1:0] req_slot_index = '0;
   logic [CountBits-1:0] req_mesh_index_count = '0;
   logic [CountBits-1:0] req_mesh_vertex_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [SlotBits-1:0] rsp_handle_slot;
   logic [GenOutBits-1:0] rsp_handle_generation;
   logic [CountBits-1:0] rsp_draw_index_count;
   logic [InstBits-1:0] rsp_draw_instance_count;
   logic [SumBits-1:0] rsp_draw_first_index;
   logic [SumBits-1:0] rsp_draw_vertex_offset;
   logic [InstBits-1:0] rsp_draw_first_instance;
   logic rsp_last;
   int fail_count;
   int pending;
   int cycles = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   instance_slot_map_draw_builder dut (.*);
   draw_builder_checker monitor (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 12) begin
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(cmd_type c, int tid, int s, int ic, int vc);
      if (!quiet && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_type_id <= TypeIdBits'(tid);
      req_slot_index <= SlotBits'(s);
      req_mesh_index_count <= CountBits'(ic);
      req_mesh_vertex_count <= CountBits'(vc);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // build walks every used slot even when it emits nothing
   task automatic write_type_count(int v);
      drain();
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_type_count <= TypeCountBits'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         send_word(CMD_LOAD, $urandom_range(0, 15), $urandom_range(0, 255),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
      else if (r < 52)
         send_word(CMD_ADD, $urandom_range(0, 15), $urandom_range(0, 255), $urandom, $urandom);
      else if (r < 92)
         send_word(CMD_DEL, $urandom_range(0, 15),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
                   $urandom, $urandom);
      else
         send_word(CMD_BUILD, $urandom_range(0, 15), $urandom_range(0, 255), $urandom, $urandom);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(CMD_BUILD, 0, 0, 0, 0);
      send_word(CMD_LOAD, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
      send_word(CMD_LOAD, 15, 255, 24'hFFFFFF, 24'hFFFFFF);
      for (int t = 1; t < 15; t++)
         send_word(CMD_LOAD, t, 0, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
      send_word(CMD_ADD, 0, 0, 0, 0);
      send_word(CMD_ADD, 15, 0, 0, 0);
      send_word(CMD_DEL, 0, 255, 0, 0);
      send_word(CMD_DEL, 0, 0, 0, 0);
      send_word(CMD_DEL, 0, 0, 0, 0);
      send_word(CMD_ADD, 3, 0, 0, 0);
      send_word(CMD_BUILD, 0, 0, 0, 0);

      write_type_count(31);
      send_word(CMD_BUILD, 0, 0, 0, 0);
      repeat (60) random_word();

      write_type_count(0);
      send_word(CMD_BUILD, 0, 0, 0, 0);
      write_type_count(16);
      for (int k = 0; k < 60; k++) send_word(CMD_ADD, $urandom_range(0, 15), 0, 0, 0);
      send_word(CMD_BUILD, 0, 0, 0, 0);
      repeat (30) random_word();

      write_type_count($urandom_range(2, 15));
      repeat (30) random_word();
      quiet = 1'b1;
      repeat (15) random_word();
      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- instance_slot_map_draw_builder.f -----
sv/isdb_pkg.sv
sv/instance_slot_map_draw_builder.sv
dv/draw_builder_checker.sv
dv/testbench.sv
